// File: src/gffrp_pkg.sv
// shared types and constants for the grid first-fit rectangle packer
// no dependencies
package gffrp_pkg;

    localparam int GRID_DEF      = 32;
    localparam int MAX_BOXES_DEF = 16;

    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_CLEARED = 2'd1;
    localparam logic [1:0] ST_NO_BOX  = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_SETUP,
        S_RD,
        S_WAIT,
        S_CHK,
        S_NEXT,
        S_MARK_RD,
        S_MARK_WAIT,
        S_MARK_WR,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request and start a place or clear
        logic clr_start;  // begin clear sweep
        logic clr_step;
        logic setup;      // set extents for current box and orientation
        logic rd;         // read row y+r
        logic chk;        // test fetched row against run mask
        logic next;       // advance candidate after a collision or when none is left
        logic row_next;   // advance r after a free row
        logic mark_rd;
        logic mark_wr;
        logic open_new;   // open a fresh box at origin
        logic res_load;   // latch result
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic is_clear;
        logic bad;
        logic clr_done;
        logic orient_ok;  // extents fit in box
        logic row_hit;    // current row collides
        logic rows_done;  // all rows of candidate checked
        logic cand_end;   // no further candidate in this orientation
        logic box_end;    // no further open box
        logic full;
        logic mark_done;
    } sts_t;

endpackage

// File: src/gffrp_ctrl.sv
// controller state machine for the rectangle packer
// depends on gffrp_pkg
module gffrp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_busy,
    input  gffrp_pkg::sts_t sts,
    output gffrp_pkg::ctl_t ctl,
    output logic            idle,
    output logic            res_set
);
    import gffrp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        res_set    = 1'b0;
        idle       = (state_reg == S_IDLE);
        case (state_reg)
            S_INIT:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (sts.is_clear)
                begin
                    ctl.clr_start = 1'b1;
                    state_next    = S_CLEAR;
                end
                else if (sts.bad)
                begin
                    ctl.res_load = 1'b1;
                    state_next   = S_OUT;
                end
                else if (sts.box_end)
                begin
                    ctl.open_new = 1'b1;
                    state_next   = sts.full ? S_OUT : S_MARK_RD;
                    ctl.res_load = sts.full;
                end
                else
                begin
                    ctl.setup  = 1'b1;
                    state_next = S_RD;
                end
            end
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    ctl.res_load = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_RD:
            begin
                if (!sts.orient_ok || sts.cand_end)
                begin
                    ctl.next   = 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    ctl.rd     = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
                state_next = S_CHK;
            S_CHK:
            begin
                ctl.chk = 1'b1;
                if (sts.row_hit)
                begin
                    ctl.next   = 1'b1;
                    state_next = S_NEXT;
                end
                else if (sts.rows_done)
                    state_next = S_MARK_RD;
                else
                begin
                    ctl.row_next = 1'b1;
                    state_next   = S_RD;
                end
            end
            S_NEXT:
                state_next = sts.box_end ? S_SETUP : S_RD;
            S_MARK_RD:
            begin
                ctl.mark_rd = 1'b1;
                state_next  = S_MARK_WAIT;
            end
            S_MARK_WAIT:
                state_next = S_MARK_WR;
            S_MARK_WR:
            begin
                ctl.mark_wr = 1'b1;
                if (sts.mark_done)
                begin
                    ctl.res_load = 1'b1;
                    state_next   = S_OUT;
                end
                else
                    state_next = S_MARK_RD;
            end
            S_OUT:
            begin
                if (!out_busy)
                begin
                    res_set    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// File: src/gffrp_dp.sv
// datapath of the rectangle packer: occupancy memory, search counters, result
// depends on gffrp_pkg
module gffrp_dp #(
    parameter int GRID      = gffrp_pkg::GRID_DEF,
    parameter int MAX_BOXES = gffrp_pkg::MAX_BOXES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  gffrp_pkg::ctl_t ctl,
    output gffrp_pkg::sts_t sts,
    input  logic            cfg_we,
    input  logic [5:0]      cfg_data,
    input  logic            in_cmd,
    input  logic [7:0]      in_w,
    input  logic [7:0]      in_h,
    output logic [1:0]      res_status,
    output logic [3:0]      res_box,
    output logic [4:0]      res_x,
    output logic [4:0]      res_y,
    output logic            res_rot,
    output logic            res_opened
);
    import gffrp_pkg::*;

    localparam int GW    = $clog2(GRID);
    localparam int CW    = $clog2(GRID + 1);
    localparam int BW    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int OBW   = $clog2(MAX_BOXES + 1);
    localparam int DEPTH = MAX_BOXES * GRID;
    localparam int AW    = $clog2(DEPTH);

    logic [GRID-1:0] mem [DEPTH];
    logic [GRID-1:0] rdata_reg;

    logic [5:0]     side_reg;
    logic           cmd_reg;
    logic [7:0]     lo_reg, sh_reg;
    logic           tall_reg;
    logic [OBW-1:0] open_reg;
    logic [OBW-1:0] box_reg;
    logic           second_reg;
    logic [CW-1:0]  ex_reg, ey_reg;
    logic [CW-1:0]  x_reg, y_reg, r_reg;
    logic [AW:0]    clr_reg;
    logic [GRID-1:0] mask_reg;
    logic [1:0]     st_reg;
    logic           opened_reg;

    logic [CW-1:0] s_eff;
    always_comb
    begin
        if (side_reg == 6'd0)
            s_eff = CW'(1);
        else if ({26'd0, side_reg} > 32'(GRID))
            s_eff = CW'(GRID);
        else
            s_eff = CW'(side_reg);
    end

    logic [GRID-1:0] run_mask;
    always_comb
    begin
        run_mask = '0;
        for (int i = 0; i < GRID; i++)
            if (32'(i) >= 32'(x_reg) && 32'(i) < 32'(x_reg) + 32'(ex_reg))
                run_mask[i] = 1'b1;
    end

    logic [CW:0] row_abs;
    assign row_abs = {1'b0, y_reg} + {1'b0, r_reg};
    logic [AW-1:0] addr;
    assign addr = AW'(box_reg[BW-1:0]) * AW'(GRID) + AW'(row_abs[GW-1:0]);

    logic [8:0] ex9, ey9;
    assign ex9 = {1'b0, second_reg ? sh_reg : lo_reg};
    assign ey9 = {1'b0, second_reg ? lo_reg : sh_reg};

    always_comb
    begin
        sts.is_clear  = cmd_reg;
        sts.bad       = (lo_reg == 8'd0) || (sh_reg == 8'd0) || ({1'b0, lo_reg} > 9'(s_eff));
        sts.clr_done  = (clr_reg == (AW+1)'(DEPTH - 1));
        sts.orient_ok = (ex9 <= 9'(s_eff)) && (ey9 <= 9'(s_eff));
        sts.row_hit   = |(rdata_reg & mask_reg);
        sts.rows_done = ({1'b0, r_reg} + 1'b1) >= (CW+1)'(ey_reg);
        sts.cand_end  = ({1'b0, y_reg} + (CW+1)'(ey_reg)) > (CW+1)'(s_eff);
        sts.box_end   = (box_reg >= open_reg);
        sts.full      = (32'(open_reg) >= 32'(MAX_BOXES));
        sts.mark_done = ({1'b0, r_reg} + 1'b1) >= (CW+1)'(ey_reg)
                        || ({1'b0, row_abs} + 1'b1) >= (CW+2)'(GRID);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clr_step)
            mem[clr_reg[AW-1:0]] <= '0;
        else if (ctl.mark_wr)
            mem[addr] <= rdata_reg | mask_reg;
        rdata_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= 6'd32;
            open_reg <= '0;
            clr_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                side_reg <= cfg_data;
            if (ctl.clr_start)
                open_reg <= '0;
            else if (ctl.open_new && !sts.full)
                open_reg <= open_reg + 1'b1;
            if (ctl.clr_start)
                clr_reg <= '0;
            else if (ctl.clr_step)
                clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= in_cmd;
            tall_reg   <= in_h > in_w;
            lo_reg     <= (in_h > in_w) ? in_h : in_w;
            sh_reg     <= (in_h > in_w) ? in_w : in_h;
            box_reg    <= '0;
            second_reg <= 1'b0;
            opened_reg <= 1'b0;
        end
        if (ctl.setup)
        begin
            ex_reg <= CW'(ex9);
            ey_reg <= CW'(ey9);
            x_reg  <= '0;
            y_reg  <= '0;
            r_reg  <= '0;
        end
        if (ctl.rd)
            mask_reg <= run_mask;
        if (ctl.row_next)
            r_reg <= r_reg + 1'b1;
        // free candidate found, marking starts at its first row
        if (ctl.chk && !sts.row_hit && sts.rows_done)
            r_reg <= '0;
        if (ctl.next)
        begin
            r_reg <= '0;
            if (sts.orient_ok && !sts.cand_end
                && ({1'b0, x_reg} + (CW+1)'(ex_reg)) < (CW+1)'(s_eff))
                x_reg <= x_reg + 1'b1;
            else if (sts.orient_ok && !sts.cand_end)
            begin
                x_reg <= '0;
                y_reg <= y_reg + 1'b1;
            end
            else if (!second_reg)
            begin
                second_reg <= 1'b1;
                ey_reg <= CW'(lo_reg);
                ex_reg <= CW'(sh_reg);
                x_reg  <= '0;
                y_reg  <= '0;
            end
            else
            begin
                second_reg <= 1'b0;
                box_reg    <= box_reg + 1'b1;
                ex_reg     <= CW'(lo_reg);
                ey_reg     <= CW'(sh_reg);
                x_reg      <= '0;
                y_reg      <= '0;
            end
        end
        if (ctl.open_new)
        begin
            box_reg    <= open_reg;
            second_reg <= 1'b0;
            opened_reg <= 1'b1;
            ex_reg     <= CW'(lo_reg);
            ey_reg     <= CW'(sh_reg);
            x_reg      <= '0;
            y_reg      <= '0;
            r_reg      <= '0;
        end
        if (ctl.mark_rd)
            mask_reg <= run_mask;
        if (ctl.mark_wr)
            r_reg <= r_reg + 1'b1;
        if (ctl.res_load)
        begin
            if (cmd_reg)
                st_reg <= ST_CLEARED;
            else if (sts.bad)
                st_reg <= ST_BAD;
            else if (ctl.open_new)
                st_reg <= ST_NO_BOX;
            else
                st_reg <= ST_PLACED;
        end
    end

    logic placed;
    assign placed = (st_reg == ST_PLACED);

    assign res_status = st_reg;
    assign res_box    = placed ? 4'(box_reg) : 4'd0;
    assign res_x      = placed ? 5'(x_reg) : 5'd0;
    assign res_y      = placed ? 5'(y_reg) : 5'd0;
    assign res_rot    = placed ? (tall_reg ^ second_reg) : 1'b0;
    assign res_opened = placed ? opened_reg : 1'b0;

endmodule

// File: src/grid_first_fit_rect_packer_core.sv
// top level of the grid first-fit rectangle packer
// depends on gffrp_pkg, gffrp_ctrl, gffrp_dp
// One request is taken at a time; s_tready is high only while the block is
// idle. After reset the occupancy memory is swept clear, during which no
// request is taken. A place request tries the open boxes in order, landscape
// then rotated: each row of a candidate is read, waited on and checked, a
// rejected candidate and the end of an orientation each pass through an extra
// advance step, so latency grows with the number of candidates tried; marking
// reads, waits on and writes each row of the rectangle. A clear request
// sweeps the whole memory. The result waits in an output register, so the
// next request can be taken while it is unread.
module grid_first_fit_rect_packer_core #(
    parameter int GRID      = gffrp_pkg::GRID_DEF,
    parameter int MAX_BOXES = gffrp_pkg::MAX_BOXES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rect_width, rect_height
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // box_index, pos_x, pos_y, rotated, opened_box
    output logic [1:0]  m_tuser    // status
);
    import gffrp_pkg::*;

    ctl_t ctl;
    sts_t sts;
    logic idle, res_set, in_fire, valid_reg;
    logic [1:0] st;
    logic [3:0] bi;
    logic [4:0] px, py;
    logic rot, opn;

    assign s_tready = idle;
    assign in_fire  = s_tvalid && s_tready;

    gffrp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_busy(valid_reg),
        .sts(sts), .ctl(ctl), .idle(idle), .res_set(res_set)
    );

    gffrp_dp #(.GRID(GRID), .MAX_BOXES(MAX_BOXES)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_cmd(s_tuser), .in_w(s_tdata[7:0]), .in_h(s_tdata[15:8]),
        .res_status(st), .res_box(bi), .res_x(px), .res_y(py),
        .res_rot(rot), .res_opened(opn)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (res_set)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_set)
        begin
            m_tdata <= {opn, rot, py, px, bi};
            m_tuser <= st;
        end
    end

    assign m_tvalid = valid_reg;

`ifndef SYNTHESIS
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while waiting");
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready) else $error("accept while busy");
    a_res_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        res_set |=> m_tvalid) else $error("result lost");
`endif

endmodule
